### rtl/nhd_pkg.sv
`timescale 1ns / 1ps
// nhd_pkg: types, codes and constants of the NRZI HDLC deframer.
// No dependencies; imported by every module of the block except nhd_fifo.
package nhd_pkg;

   localparam int CountW    = 11;
   localparam int ByteW     = 8;
   localparam int FrameCntW = 16;
   localparam int KindW     = 3;

   localparam int MaxFrameBytes = 1024;
   localparam int QueueDepth    = 4;

   localparam int CapClamp = (MaxFrameBytes > (2 ** CountW) - 1) ?
                             (2 ** CountW) - 1 : MaxFrameBytes;
   localparam logic [CountW-1:0] CapLimit = CountW'(CapClamp);

   localparam logic [CountW-1:0] MinFrameReset = 11'd17;
   localparam logic [CountW-1:0] MaxFrameReset = 11'd1024;

   localparam logic [ByteW-1:0] FlagPattern  = 8'h7E;
   localparam logic [ByteW-1:0] AbortMask    = 8'h7F;
   localparam logic [ByteW-1:0] StuffMask    = 8'h3F;
   localparam logic [ByteW-1:0] StuffPattern = 8'h3E;

   typedef enum logic [KindW-1:0] {
      KIND_DATA  = 3'd0,
      KIND_VALID = 3'd1,
      KIND_SHORT = 3'd2,
      KIND_ABORT = 3'd3,
      KIND_FULL  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      BIT_DATA,
      BIT_FLAG,
      BIT_ABORT,
      BIT_STUFF
   } bit_class_type;

   typedef struct packed {
      bit_class_type cls;
      logic          value;
   } bit_item_type;

   typedef struct packed {
      kind_type              kind;
      logic [ByteW-1:0]      data_byte;
      logic [CountW-1:0]     byte_count;
      logic [FrameCntW-1:0]  frame_count;
   } result_type;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_MIN_FRAME = 1'b0;
   localparam csr_index_type CSR_MAX_FRAME = 1'b1;

   typedef struct packed {
      logic              write;
      csr_index_type     index;
      logic [CountW-1:0] data;
   } csr_write_type;

endpackage

### rtl/nhd_fifo.sv
`timescale 1ns / 1ps
// nhd_fifo: small register queue, first word fall-through.
// Generic; no package dependency.
module nhd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/nhd_front.sv
`timescale 1ns / 1ps
// nhd_front: NRZI decode, bit history and per-bit classification.
// Depends on nhd_pkg.
module nhd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  tone,
   output nhd_pkg::bit_item_type item
);
   import nhd_pkg::*;

   logic             last_tone_ff, last_tone_in;
   logic [ByteW-1:0] history_ff, history_in;
   logic             bit_value;

   assign bit_value    = (tone == last_tone_ff);
   assign history_in   = {history_ff[ByteW-2:0], bit_value};
   assign last_tone_in = tone;

   always_comb begin
      item.value = bit_value;
      if (history_in == FlagPattern) begin
         item.cls = BIT_FLAG;
      end else if ((history_in & AbortMask) == AbortMask) begin
         item.cls = BIT_ABORT;
      end else if ((history_in & StuffMask) == StuffPattern) begin
         item.cls = BIT_STUFF;
      end else begin
         item.cls = BIT_DATA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_tone_ff <= 1'b0;
         history_ff   <= '0;
      end else if (accept) begin
         last_tone_ff <= last_tone_in;
         history_ff   <= history_in;
      end
   end

endmodule

### rtl/nhd_back.sv
`timescale 1ns / 1ps
// nhd_back: frame state, byte assembly, counters and configuration registers.
// Depends on nhd_pkg.
module nhd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  nhd_pkg::csr_write_type csr,
   input  logic                   item_valid,
   input  nhd_pkg::bit_item_type  item,
   output logic                   item_take,
   input  logic                   result_full,
   output logic                   result_push,
   output nhd_pkg::result_type    result
);
   import nhd_pkg::*;

   logic [CountW-1:0]    min_ff, max_ff;
   logic                 in_frame_ff, in_frame_in;
   logic [ByteW-1:0]     acc_ff, acc_in, acc_next;
   logic [2:0]           bib_ff, bib_in;
   logic [CountW-1:0]    fb_ff, fb_in;
   logic [FrameCntW-1:0] gf_ff, gf_in;
   logic [CountW-1:0]    cap;
   logic                 emit;
   kind_type             kind;
   logic [ByteW-1:0]     data;

   assign item_take = item_valid && !result_full;
   assign cap       = (max_ff > CapLimit) ? CapLimit : max_ff;
   assign acc_next  = {item.value, acc_ff[ByteW-1:1]};

   always_comb begin
      in_frame_in = in_frame_ff;
      acc_in      = acc_ff;
      bib_in      = bib_ff;
      fb_in       = fb_ff;
      gf_in       = gf_ff;
      emit        = 1'b0;
      kind        = KIND_DATA;
      data        = '0;
      if (item_take) begin
         if (!in_frame_ff) begin
            if (item.cls == BIT_FLAG) begin
               in_frame_in = 1'b1;
               fb_in       = '0;
               bib_in      = '0;
            end
         end else begin
            case (item.cls)
               BIT_FLAG: begin
                  bib_in = '0;
                  emit   = 1'b1;
                  if (fb_ff >= min_ff) begin
                     gf_in       = gf_ff + 1'b1;
                     in_frame_in = 1'b0;
                     kind        = KIND_VALID;
                  end else begin
                     fb_in = '0;
                     kind  = KIND_SHORT;
                  end
               end
               BIT_ABORT: begin
                  in_frame_in = 1'b0;
                  emit        = 1'b1;
                  kind        = KIND_ABORT;
               end
               BIT_STUFF: begin
               end
               default: begin
                  acc_in = acc_next;
                  bib_in = bib_ff + 1'b1;
                  if (bib_ff == '1) begin
                     emit = 1'b1;
                     if (fb_ff < cap) begin
                        fb_in = fb_ff + 1'b1;
                        kind  = KIND_DATA;
                        data  = acc_next;
                     end else begin
                        in_frame_in = 1'b0;
                        kind        = KIND_FULL;
                     end
                  end
               end
            endcase
         end
      end
   end

   assign result_push        = item_take && emit;
   assign result.kind        = kind;
   assign result.data_byte   = data;
   assign result.byte_count  = fb_in;
   assign result.frame_count = gf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= MinFrameReset;
         max_ff      <= MaxFrameReset;
         in_frame_ff <= 1'b0;
         acc_ff      <= '0;
         bib_ff      <= '0;
         fb_ff       <= '0;
         gf_ff       <= '0;
      end else begin
         if (csr.write && csr.index == CSR_MIN_FRAME) begin
            min_ff <= csr.data;
         end
         if (csr.write && csr.index == CSR_MAX_FRAME) begin
            max_ff <= csr.data;
         end
         in_frame_ff <= in_frame_in;
         acc_ff      <= acc_in;
         bib_ff      <= bib_in;
         fb_ff       <= fb_in;
         gf_ff       <= gf_in;
      end
   end

endmodule

### rtl/nrzi_hdlc_deframer_top.sv
`timescale 1ns / 1ps
// nrzi_hdlc_deframer_top: NRZI decoding, HDLC destuffing and deframing.
// Depends on nhd_pkg, nhd_front, nhd_back and nhd_fifo.
// Throughput: one tone per cycle while req_full is low, limited by the per-bit front update.
// Path: a taken request passes through the bit queue, then the result queue, before its
// result shows on the rsp_ ports; a full result queue or a low rsp_pop holds it back.
// Reset: synchronous; clears both queues and all frame state, loads register defaults.
module nrzi_hdlc_deframer_top #(
   parameter int QUEUE_DEPTH = nhd_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_tone,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [nhd_pkg::KindW-1:0]     rsp_kind,
   output logic [nhd_pkg::ByteW-1:0]     rsp_data_byte,
   output logic [nhd_pkg::CountW-1:0]    rsp_byte_count,
   output logic [nhd_pkg::FrameCntW-1:0] rsp_frame_count,
   input  logic                          csr_write,
   input  nhd_pkg::csr_index_type        csr_index,
   input  logic [nhd_pkg::CountW-1:0]    csr_data
);
   import nhd_pkg::*;

   bit_item_type  front_item, back_item;
   logic          accept, q_empty, back_take;
   logic          res_full, res_push;
   result_type    res_in, res_out;
   csr_write_type csr;

   assign accept    = req_push && !req_full;
   assign csr.write = csr_write;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   nhd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .tone   (req_tone),
      .item   (front_item)
   );

   nhd_fifo #(
      .WIDTH ($bits(bit_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_bit_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (front_item),
      .full    (req_full),
      .pop     (back_take),
      .rd_data (back_item),
      .empty   (q_empty)
   );

   nhd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .item_valid  (!q_empty),
      .item        (back_item),
      .item_take   (back_take),
      .result_full (res_full),
      .result_push (res_push),
      .result      (res_in)
   );

   nhd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_in),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (res_out),
      .empty   (rsp_empty)
   );

   assign rsp_kind        = res_out.kind;
   assign rsp_data_byte   = res_out.data_byte;
   assign rsp_byte_count  = res_out.byte_count;
   assign rsp_frame_count = res_out.frame_count;

endmodule

### rtl/nhd_checker.sv
`timescale 1ns / 1ps
// nhd_checker: port-level assertions for the deframer, bound to its top level.
// Depends on nhd_pkg and nrzi_hdlc_deframer_top.
module nhd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [nhd_pkg::KindW-1:0]     rsp_kind,
   input logic [nhd_pkg::ByteW-1:0]     rsp_data_byte,
   input logic [nhd_pkg::CountW-1:0]    rsp_byte_count,
   input logic [nhd_pkg::FrameCntW-1:0] rsp_frame_count
);
   import nhd_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_event_no_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != KIND_DATA) |-> rsp_data_byte == '0)
      else $error("data byte set on a non-data result");

   a_data_counted: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_DATA) |-> rsp_byte_count != '0)
      else $error("data byte with zero byte count");

   a_short_cleared: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_SHORT) |-> rsp_byte_count == '0)
      else $error("short frame restart with nonzero byte count");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_kind) &&
         $stable(rsp_data_byte) && $stable(rsp_byte_count) && $stable(rsp_frame_count))
      else $error("result changed while stalled");

endmodule

bind nrzi_hdlc_deframer_top nhd_checker u_nhd_checker (.*);

### tb/nrzi_hdlc_deframer_top_tb.sv
`timescale 1ns / 1ps
// nrzi_hdlc_deframer_top_tb: self-checking bench for the NRZI HDLC deframer.
// Depends on nhd_pkg and nrzi_hdlc_deframer_top; NRZI-encoded, bit-stuffed frames,
// aborts and noise are pushed and every result is checked against a local predictor.
module nrzi_hdlc_deframer_top_tb;
   import nhd_pkg::*;

   localparam int WatchdogLimit = 3000;
   localparam int DrainCycles   = 12;
   localparam int HoldStart     = 60;
   localparam int HoldCycles    = 400;
   localparam int QuietFrom     = 470;
   localparam int QuietTo       = 590;
   localparam int RandomPhases  = 4;
   localparam int PhaseTones    = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic                 req_tone = 1'b0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [KindW-1:0]     rsp_kind;
   logic [ByteW-1:0]     rsp_data_byte;
   logic [CountW-1:0]    rsp_byte_count;
   logic [FrameCntW-1:0] rsp_frame_count;
   logic                 csr_write = 1'b0;
   csr_index_type        csr_index = CSR_MIN_FRAME;
   logic [CountW-1:0]    csr_data = '0;

   nrzi_hdlc_deframer_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_tone        (req_tone),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_frame_count (rsp_frame_count),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // predictor state and its copy of the registers
   logic                 last_tone_q = 1'b0;
   logic [ByteW-1:0]     history_q = '0;
   logic [ByteW-1:0]     accum_q = '0;
   logic [2:0]           bit_cnt_q = '0;
   logic                 framing_q = 1'b0;
   logic [CountW-1:0]    frame_bytes_q = '0;
   logic [FrameCntW-1:0] good_frames_q = '0;
   logic [CountW-1:0]    cfg_min = MinFrameReset;
   logic [CountW-1:0]    cfg_max = MaxFrameReset;

   logic       tone_backlog[$];
   result_type expected_events[$];

   int   cycle_count = 0;
   int   tones_queued = 0;
   int   tones_taken = 0;
   int   results_checked = 0;
   int   mismatches = 0;
   int   idle_cycles = 0;
   int   hold_left = 0;
   int   settings_used = 1;
   int   kind_seen[5] = '{default: 0};
   logic enc_tone = 1'b0;
   int   ones_run = 0;
   logic quiet;

   assign quiet = (cycle_count >= QuietFrom) && (cycle_count < QuietTo);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic bit deframe_tone(input logic tone, output result_type ev);
      logic              nrz_bit;
      logic [CountW-1:0] cap;
      nrz_bit = (tone == last_tone_q);
      last_tone_q = tone;
      history_q = {history_q[ByteW-2:0], nrz_bit};
      ev = '0;
      if (!framing_q) begin
         if (history_q == FlagPattern) begin
            framing_q = 1'b1;
            frame_bytes_q = '0;
            bit_cnt_q = '0;
         end
         return 1'b0;
      end
      if (history_q == FlagPattern) begin
         bit_cnt_q = '0;
         if (frame_bytes_q >= cfg_min) begin
            good_frames_q = good_frames_q + 1'b1;
            framing_q = 1'b0;
            ev.kind = KIND_VALID;
         end else begin
            frame_bytes_q = '0;
            ev.kind = KIND_SHORT;
         end
      end else if ((history_q & AbortMask) == AbortMask) begin
         framing_q = 1'b0;
         ev.kind = KIND_ABORT;
      end else if ((history_q & StuffMask) == StuffPattern) begin
         return 1'b0;
      end else begin
         accum_q = {nrz_bit, accum_q[ByteW-1:1]};
         bit_cnt_q = bit_cnt_q + 1'b1;
         if (bit_cnt_q != '0) return 1'b0;
         cap = (cfg_max > CapLimit) ? CapLimit : cfg_max;
         if (frame_bytes_q < cap) begin
            frame_bytes_q = frame_bytes_q + 1'b1;
            ev.kind = KIND_DATA;
            ev.data_byte = accum_q;
         end else begin
            framing_q = 1'b0;
            ev.kind = KIND_FULL;
         end
      end
      ev.byte_count = frame_bytes_q;
      ev.frame_count = good_frames_q;
      return 1'b1;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || !req_full) begin
         if (tone_backlog.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
            req_tone <= tone_backlog.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // result sink, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_pop <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (cycle_count == HoldStart) begin
         rsp_pop <= 1'b0;
         hold_left <= HoldCycles;
      end else begin
         rsp_pop <= quiet || ($urandom_range(99) >= 13);
      end
   end

   // monitor: predicts on each taken request, checks each popped result
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset) begin
         idle_cycles++;
         if (req_push && !req_full) begin
            idle_cycles = 0;
            tones_taken++;
            if (deframe_tone(req_tone, want)) expected_events.push_back(want);
         end
         if (rsp_pop && !rsp_empty) begin
            idle_cycles = 0;
            results_checked++;
            got.kind = kind_type'(rsp_kind);
            got.data_byte = rsp_data_byte;
            got.byte_count = rsp_byte_count;
            got.frame_count = rsp_frame_count;
            if (expected_events.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: kind %0d byte %02h count %0d frames %0d",
                           rsp_kind, rsp_data_byte, rsp_byte_count, rsp_frame_count);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               kind_seen[int'(want.kind)]++;
               if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                   got.byte_count !== want.byte_count ||
                   got.frame_count !== want.frame_count) begin
                  if (mismatches < 10)
                     $display("mismatch: expected kind %0d byte %02h count %0d frames %0d, %s",
                              want.kind, want.data_byte, want.byte_count,
                              want.frame_count, "got");
                  if (mismatches < 10)
                     $display("          actual   kind %0d byte %02h count %0d frames %0d",
                              rsp_kind, rsp_data_byte, rsp_byte_count, rsp_frame_count);
                  mismatches++;
               end
            end
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_tone(input logic tone);
      enc_tone = tone;
      tone_backlog.push_back(tone);
      tones_queued++;
   endtask

   // NRZI: a 1 keeps the tone, a 0 toggles it
   task automatic send_bit(input logic b);
      send_tone(b ? enc_tone : ~enc_tone);
   endtask

   task automatic send_stuffed_bit(input logic b);
      send_bit(b);
      if (b) begin
         ones_run++;
         if (ones_run == 5) begin
            send_bit(1'b0);
            ones_run = 0;
         end
      end else begin
         ones_run = 0;
      end
   endtask

   task automatic send_flag();
      for (int i = 0; i < ByteW; i++) send_bit(FlagPattern[i]);
      ones_run = 0;
   endtask

   task automatic send_byte(input logic [ByteW-1:0] value);
      for (int i = 0; i < ByteW; i++) send_stuffed_bit(value[i]);
   endtask

   task automatic send_bytes(input int count);
      for (int i = 0; i < count; i++) send_byte(ByteW'($urandom_range(255)));
   endtask

   task automatic send_abort();
      int run;
      run = $urandom_range(7, 10);
      for (int i = 0; i < run; i++) send_bit(1'b1);
      ones_run = 0;
   endtask

   task automatic settle();
      while (tones_taken != tones_queued || expected_events.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic set_config(input logic [CountW-1:0] min_bytes,
                             input logic [CountW-1:0] max_bytes);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_MIN_FRAME;
      csr_data  <= min_bytes;
      @(posedge clock);
      csr_index <= CSR_MAX_FRAME;
      csr_data  <= max_bytes;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_min = min_bytes;
      cfg_max = max_bytes;
      settings_used++;
      @(negedge clock);
   endtask

   initial begin
      logic [CountW-1:0] min_pick;
      logic [CountW-1:0] max_pick;
      int                phase_start;
      int                pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: hunting noise, valid frame, short restart, abort
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b1);
      send_flag();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7E);
      send_byte(8'h3E);
      send_bytes(13);
      send_flag();
      send_flag();
      send_bytes(2);
      send_flag();
      send_bytes(1);
      send_abort();
      settle();

      // one-byte capacity, zero minimum: empty frame closes as valid
      set_config(11'd0, 11'd1);
      send_flag();
      send_flag();
      send_flag();
      send_bytes(2);
      send_flag();
      send_bytes(1);
      send_flag();
      settle();

      // zero capacity, minimum above it
      set_config(11'd1024, 11'd0);
      send_flag();
      send_bytes(1);
      send_flag();
      send_flag();
      send_flag();
      send_abort();
      settle();

      // capacity register above the buffer limit
      set_config(11'd0, 11'd2047);
      send_flag();
      send_bytes(3);
      send_flag();
      settle();

      for (int p = 0; p < RandomPhases; p++) begin
         pick = (p < 2) ? p * 3 : $urandom_range(4);
         case (pick)
            0: min_pick = '0;
            1: min_pick = CountW'($urandom_range(1, 6));
            2: min_pick = 11'd1024;
            3: min_pick = 11'd2047;
            default: min_pick = CountW'($urandom_range(2047));
         endcase
         pick = (p < 2) ? 4 - p * 4 : $urandom_range(4);
         case (pick)
            0: max_pick = '0;
            1: max_pick = 11'd1;
            2: max_pick = CountW'($urandom_range(2, 8));
            3: max_pick = 11'd1024;
            default: max_pick = 11'd2047;
         endcase
         set_config(min_pick, max_pick);
         phase_start = tones_queued;
         while (tones_queued - phase_start < PhaseTones) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               send_flag();
               send_bytes($urandom_range(0, 8));
               if ($urandom_range(3) == 0)
                  repeat ($urandom_range(1, 7)) send_stuffed_bit(1'($urandom_range(1)));
               send_flag();
            end else if (pick < 80) begin
               send_flag();
               send_bytes($urandom_range(0, 4));
               send_abort();
            end else if (pick < 90) begin
               repeat ($urandom_range(5, 30)) send_tone(1'($urandom_range(1)));
               ones_run = 0;
            end else begin
               repeat ($urandom_range(2, 4)) send_flag();
            end
         end
         settle();
      end

      $display("Covered %0d tones over %0d register settings, %0d results checked.",
               tones_taken, settings_used, results_checked);
      $display("Events seen: %0d data, %0d valid, %0d short, %0d abort, %0d buffer full.",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
